@@ rtl/qrs_pkg.sv @@
// shared types and constants for the quadratic root solver
// no dependencies; used by every module under rtl
package qrs_pkg;

	localparam int COEF_W  = 16;
	localparam int ROOT_W  = 25;
	localparam int RAD_W   = 36;
	localparam int SQRT_W  = 18;
	localparam int SREM_W  = 21;
	localparam int MAG_W   = 18;
	localparam int DREM_W  = 16;
	localparam int SQ_STEP = 2;
	localparam int SQ_NST  = SQRT_W / SQ_STEP;
	localparam int DV_STEP = 5;
	localparam int DV_NST  = ROOT_W / DV_STEP;

	localparam logic [1:0] COUNT_NONE    = 2'd0;
	localparam logic [1:0] COUNT_COMPLEX = 2'd2;

	typedef struct packed {
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic                     dneg;
		logic                     zl;
	} sq_side_t;

	typedef struct packed {
		logic sgn1;
		logic sgn2;
		logic dneg;
		logic zl;
	} dv_side_t;

	typedef struct packed {
		logic [SREM_W-1:0] rem;
		logic [SQRT_W-1:0] root;
		logic [RAD_W-1:0]  rad;
	} sq_lane_t;

	typedef struct packed {
		logic [DREM_W-1:0] rem;
		logic [ROOT_W-1:0] dvd;
	} dv_lane_t;

endpackage

@@ rtl/qrs_disc.sv @@
// discriminant stages: products, then |b*b - 4*a*c| and its sign
// depends on qrs_pkg
module qrs_disc (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [qrs_pkg::COEF_W-1:0]  a,
	input  logic signed [qrs_pkg::COEF_W-1:0]  b,
	input  logic signed [qrs_pkg::COEF_W-1:0]  c,
	output logic                               out_valid,
	output logic [qrs_pkg::RAD_W-1:0]          out_rad,
	output qrs_pkg::sq_side_t                  out_side
);

	logic               valid_s1, valid_s2;
	logic signed [31:0] bb_s1, ac_s1;
	logic signed [15:0] a_s1, b_s1;
	logic signed [33:0] d;
	logic [33:0]        dmag;
	logic [qrs_pkg::RAD_W-1:0] rad_s2;
	qrs_pkg::sq_side_t  side_s2;

	assign d    = 34'(bb_s1) - (34'(ac_s1) <<< 2);
	assign dmag = d[33] ? 34'(-d) : d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		bb_s1 <= b * b;
		ac_s1 <= a * c;
		a_s1  <= a;
		b_s1  <= b;
		rad_s2       <= {2'b00, dmag};
		side_s2.a    <= a_s1;
		side_s2.b    <= b_s1;
		side_s2.dneg <= d[33];
		side_s2.zl   <= (a_s1 == '0);
	end

	assign out_valid = valid_s2;
	assign out_rad   = rad_s2;
	assign out_side  = side_s2;

endmodule

@@ rtl/qrs_sqrt.sv @@
// pipelined integer square root, two root bits per stage
// depends on qrs_pkg
module qrs_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [qrs_pkg::RAD_W-1:0]   in_rad,
	input  qrs_pkg::sq_side_t           in_side,
	output logic                        out_valid,
	output logic [qrs_pkg::SQRT_W-1:0]  out_root,
	output qrs_pkg::sq_side_t           out_side
);

	localparam int NST = qrs_pkg::SQ_NST;

	function automatic qrs_pkg::sq_lane_t sq_steps(qrs_pkg::sq_lane_t x);
		qrs_pkg::sq_lane_t y;
		logic [qrs_pkg::SREM_W-1:0] t;
		y = x;
		for (int i = 0; i < qrs_pkg::SQ_STEP; i++) begin
			y.rem = {y.rem[qrs_pkg::SREM_W-3:0], y.rad[qrs_pkg::RAD_W-1 -: 2]};
			y.rad = {y.rad[qrs_pkg::RAD_W-3:0], 2'b00};
			t = {1'b0, y.root, 2'b01};
			if (y.rem >= t) begin
				y.rem  = y.rem - t;
				y.root = {y.root[qrs_pkg::SQRT_W-2:0], 1'b1};
			end else begin
				y.root = {y.root[qrs_pkg::SQRT_W-2:0], 1'b0};
			end
		end
		return y;
	endfunction

	logic              valid_s [NST];
	qrs_pkg::sq_lane_t lane_s  [NST];
	qrs_pkg::sq_side_t side_s  [NST];

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic              v_in;
		qrs_pkg::sq_lane_t l_in;
		qrs_pkg::sq_side_t sd_in;
		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign l_in  = '{rem: '0, root: '0, rad: in_rad};
			assign sd_in = in_side;
		end else begin : g_next
			assign v_in  = valid_s[k-1];
			assign l_in  = lane_s[k-1];
			assign sd_in = side_s[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[k] <= 1'b0;
			else valid_s[k] <= v_in;
		end
		always_ff @(posedge clk) begin
			lane_s[k] <= sq_steps(l_in);
			side_s[k] <= sd_in;
		end
	end

	assign out_valid = valid_s[NST-1];
	assign out_root  = lane_s[NST-1].root;
	assign out_side  = side_s[NST-1];

endmodule

@@ rtl/qrs_div.sv @@
// two-lane pipelined restoring divider with a shared divisor, five bits per stage
// depends on qrs_pkg
module qrs_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [qrs_pkg::MAG_W-1:0]   in_mag1,
	input  logic [qrs_pkg::MAG_W-1:0]   in_mag2,
	input  logic [qrs_pkg::COEF_W-1:0]  in_den,
	input  qrs_pkg::dv_side_t           in_side,
	output logic                        out_valid,
	output logic [qrs_pkg::ROOT_W-1:0]  out_q1,
	output logic [qrs_pkg::ROOT_W-1:0]  out_q2,
	output qrs_pkg::dv_side_t           out_side
);

	localparam int NST = qrs_pkg::DV_NST;
	localparam int PAD = qrs_pkg::ROOT_W - qrs_pkg::MAG_W;

	function automatic qrs_pkg::dv_lane_t dv_steps(qrs_pkg::dv_lane_t x,
			logic [qrs_pkg::COEF_W-1:0] den);
		qrs_pkg::dv_lane_t y;
		logic [qrs_pkg::DREM_W:0] sh;
		y = x;
		for (int i = 0; i < qrs_pkg::DV_STEP; i++) begin
			sh = {y.rem, y.dvd[qrs_pkg::ROOT_W-1]};
			y.dvd = {y.dvd[qrs_pkg::ROOT_W-2:0], 1'b0};
			if (sh >= {1'b0, den}) begin
				sh = sh - {1'b0, den};
				y.dvd[0] = 1'b1;
			end
			y.rem = sh[qrs_pkg::DREM_W-1:0];
		end
		return y;
	endfunction

	logic                       valid_s [NST];
	qrs_pkg::dv_lane_t          l1_s    [NST];
	qrs_pkg::dv_lane_t          l2_s    [NST];
	logic [qrs_pkg::COEF_W-1:0] den_s   [NST];
	qrs_pkg::dv_side_t          side_s  [NST];

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic                       v_in;
		qrs_pkg::dv_lane_t          l1_in, l2_in;
		logic [qrs_pkg::COEF_W-1:0] den_in;
		qrs_pkg::dv_side_t          sd_in;
		if (k == 0) begin : g_first
			assign v_in   = in_valid;
			assign l1_in  = '{rem: '0, dvd: {in_mag1, {PAD{1'b0}}}};
			assign l2_in  = '{rem: '0, dvd: {in_mag2, {PAD{1'b0}}}};
			assign den_in = in_den;
			assign sd_in  = in_side;
		end else begin : g_next
			assign v_in   = valid_s[k-1];
			assign l1_in  = l1_s[k-1];
			assign l2_in  = l2_s[k-1];
			assign den_in = den_s[k-1];
			assign sd_in  = side_s[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[k] <= 1'b0;
			else valid_s[k] <= v_in;
		end
		always_ff @(posedge clk) begin
			l1_s[k]   <= dv_steps(l1_in, den_in);
			l2_s[k]   <= dv_steps(l2_in, den_in);
			den_s[k]  <= den_in;
			side_s[k] <= sd_in;
		end
	end

	assign out_valid = valid_s[NST-1];
	assign out_q1    = l1_s[NST-1].dvd;
	assign out_q2    = l2_s[NST-1].dvd;
	assign out_side  = side_s[NST-1];

endmodule

@@ rtl/quadratic_root_solver.sv @@
// done is registered and goes high once an accepted item has passed every stage listed below
// throughput: one item per cycle; busy is tied low, the pipeline never stalls
// depth: discriminant (2 stages), square root (9 stages, 2 bits each),
// divider (5 stages, 5 bits each) and the result register (1 stage)
// reset clears only the valid bits; no item in flight survives reset
module quadratic_root_solver (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [qrs_pkg::COEF_W-1:0]  coef_a,
	input  logic signed [qrs_pkg::COEF_W-1:0]  coef_b,
	input  logic signed [qrs_pkg::COEF_W-1:0]  coef_c,
	output logic                               done,
	output logic signed [qrs_pkg::ROOT_W-1:0]  root1_re,
	output logic signed [qrs_pkg::ROOT_W-1:0]  root1_im,
	output logic signed [qrs_pkg::ROOT_W-1:0]  root2_re,
	output logic signed [qrs_pkg::ROOT_W-1:0]  root2_im,
	output logic [1:0]                         complex_count,
	output logic                               zero_leading
);

	// discriminant to square root
	logic                       dc_valid;
	logic [qrs_pkg::RAD_W-1:0]  dc_rad;
	qrs_pkg::sq_side_t          dc_side;

	// square root to divider
	logic                       sq_valid;
	logic [qrs_pkg::SQRT_W-1:0] sq_root;
	qrs_pkg::sq_side_t          sq_side;

	// numerators and divisor
	logic signed [18:0]         nb, sv, n1, n2;
	logic [qrs_pkg::MAG_W-1:0]  m1, m2;
	logic [qrs_pkg::COEF_W-1:0] den;
	qrs_pkg::dv_side_t          dv_in_side;

	// divider results
	logic                       dv_valid;
	logic [qrs_pkg::ROOT_W-1:0] q1, q2;
	qrs_pkg::dv_side_t          dv_side;
	logic signed [qrs_pkg::ROOT_W-1:0] q1s, q2s;

	logic                              done_q;
	logic signed [qrs_pkg::ROOT_W-1:0] r1re_q, r1im_q, r2re_q, r2im_q;
	logic [1:0]                        cnt_q;
	logic                              zl_q;

	// no backpressure anywhere: every start is taken
	assign busy = 1'b0;

	qrs_disc u_disc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.a         (coef_a),
		.b         (coef_b),
		.c         (coef_c),
		.out_valid (dc_valid),
		.out_rad   (dc_rad),
		.out_side  (dc_side)
	);

	qrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dc_valid),
		.in_rad    (dc_rad),
		.in_side   (dc_side),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// real case: (-b+s, -b-s); complex case: (-b, s) for real and imaginary parts
	assign nb = -19'(sq_side.b);
	assign sv = $signed({1'b0, sq_root});
	assign n1 = sq_side.dneg ? nb : nb + sv;
	assign n2 = sq_side.dneg ? sv : nb - sv;
	// magnitudes stay below 2^17, so the top bit of the 19-bit form is dropped
	assign m1 = n1[18] ? 18'(-n1) : 18'(n1);
	assign m2 = n2[18] ? 18'(-n2) : 18'(n2);
	// magnitude of a; the most negative a maps to 0x8000, which is right
	assign den = sq_side.a[15] ? 16'(-sq_side.a) : sq_side.a;

	assign dv_in_side.sgn1 = n1[18] ^ sq_side.a[15];
	assign dv_in_side.sgn2 = n2[18] ^ sq_side.a[15];
	assign dv_in_side.dneg = sq_side.dneg;
	assign dv_in_side.zl   = sq_side.zl;

	qrs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_mag1   (m1),
		.in_mag2   (m2),
		.in_den    (den),
		.in_side   (dv_in_side),
		.out_valid (dv_valid),
		.out_q1    (q1),
		.out_q2    (q2),
		.out_side  (dv_side)
	);

	// truncation toward zero: divide magnitudes, then restore the sign
	assign q1s = dv_side.sgn1 ? -$signed(q1) : $signed(q1);
	assign q2s = dv_side.sgn2 ? -$signed(q2) : $signed(q2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= dv_valid;
	end

	// result register; a zero leading coefficient forces all roots to zero
	always_ff @(posedge clk) begin
		zl_q <= dv_side.zl;
		if (dv_side.zl) begin
			r1re_q <= '0;
			r1im_q <= '0;
			r2re_q <= '0;
			r2im_q <= '0;
			cnt_q  <= qrs_pkg::COUNT_NONE;
		end else if (dv_side.dneg) begin
			r1re_q <= q1s;
			r2re_q <= q1s;
			r1im_q <= q2s;
			r2im_q <= -q2s;
			cnt_q  <= (q2s != '0) ? qrs_pkg::COUNT_COMPLEX : qrs_pkg::COUNT_NONE;
		end else begin
			r1re_q <= q1s;
			r2re_q <= q2s;
			r1im_q <= '0;
			r2im_q <= '0;
			cnt_q  <= qrs_pkg::COUNT_NONE;
		end
	end

	assign done          = done_q;
	assign root1_re      = r1re_q;
	assign root1_im      = r1im_q;
	assign root2_re      = r2re_q;
	assign root2_im      = r2im_q;
	assign complex_count = cnt_q;
	assign zero_leading  = zl_q;

`ifndef NO_ASSERTIONS
	// every accepted item is followed by done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##17 done)
		else $error("item did not complete after fixed latency");

	// a zero leading coefficient never yields a nonzero root
	a_zero_lead: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_leading |-> root1_re == '0 && root2_re == '0 &&
			root1_im == '0 && root2_im == '0 && complex_count == qrs_pkg::COUNT_NONE)
		else $error("roots nonzero with zero leading coefficient");

	// complex roots are a conjugate pair with a nonzero imaginary part
	a_conjugate: assert property (@(posedge clk) disable iff (!arst_n)
		done && complex_count == qrs_pkg::COUNT_COMPLEX |->
			root1_im != '0 && root2_im == -root1_im && root1_re == root2_re)
		else $error("complex roots are not a conjugate pair");
`endif

endmodule

@@ tb/quadratic_root_solver_chk.sv @@
// checker for the quadratic root solver: predicts roots of each accepted item
// and compares them with each result strobe; depends on qrs_pkg
module quadratic_root_solver_chk (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic signed [qrs_pkg::COEF_W-1:0]  coef_a,
	input  logic signed [qrs_pkg::COEF_W-1:0]  coef_b,
	input  logic signed [qrs_pkg::COEF_W-1:0]  coef_c,
	input  logic                               done,
	input  logic signed [qrs_pkg::ROOT_W-1:0]  root1_re,
	input  logic signed [qrs_pkg::ROOT_W-1:0]  root1_im,
	input  logic signed [qrs_pkg::ROOT_W-1:0]  root2_re,
	input  logic signed [qrs_pkg::ROOT_W-1:0]  root2_im,
	input  logic [1:0]                         complex_count,
	input  logic                               zero_leading,
	output int                                 fail_count,
	output int                                 roots_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [qrs_pkg::ROOT_W-1:0] r1re, r1im, r2re, r2im;
		logic [1:0]                        cnt;
		logic                              zl;
	} roots_t;

	roots_t expected_roots[$];

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 64'd4294967296;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (mid * mid <= v) lo = mid;
			else hi = mid;
		end
		return lo;
	endfunction

	function automatic roots_t solve_roots(longint a, longint b, longint c);
		roots_t r;
		longint d, s, im;
		r = '{default: '0};
		r.cnt = qrs_pkg::COUNT_NONE;
		if (a == 0) begin
			r.zl = 1'b1;
		end else begin
			d = b * b - 4 * a * c;
			s = longint'(int_sqrt(d < 0 ? -d : d));
			if (d >= 0) begin
				r.r1re = qrs_pkg::ROOT_W'(((-b + s) * 128) / a);
				r.r2re = qrs_pkg::ROOT_W'(((-b - s) * 128) / a);
			end else begin
				r.r1re = qrs_pkg::ROOT_W'((-b * 128) / a);
				r.r2re = r.r1re;
				im = (s * 128) / a;
				r.r1im = qrs_pkg::ROOT_W'(im);
				r.r2im = qrs_pkg::ROOT_W'(-im);
				if (im != 0) r.cnt = qrs_pkg::COUNT_COMPLEX;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		roots_t e;
		if (!arst_n) begin
			fail_count = 0;
		end else begin
			if (start && !busy)
				expected_roots.push_back(solve_roots(coef_a, coef_b, coef_c));
			if (done) begin
				if (expected_roots.size() == 0) begin
					$error("result with no item outstanding");
					fail_count++;
				end else begin
					e = expected_roots.pop_front();
					if (root1_re !== e.r1re) begin
						$error("root1_re exp %0d got %0d", e.r1re, root1_re); fail_count++;
					end
					if (root1_im !== e.r1im) begin
						$error("root1_im exp %0d got %0d", e.r1im, root1_im); fail_count++;
					end
					if (root2_re !== e.r2re) begin
						$error("root2_re exp %0d got %0d", e.r2re, root2_re); fail_count++;
					end
					if (root2_im !== e.r2im) begin
						$error("root2_im exp %0d got %0d", e.r2im, root2_im); fail_count++;
					end
					if (complex_count !== e.cnt) begin
						$error("complex_count exp %0d got %0d", e.cnt, complex_count);
						fail_count++;
					end
					if (zero_leading !== e.zl) begin
						$error("zero_leading exp %0d got %0d", e.zl, zero_leading);
						fail_count++;
					end
				end
			end
		end
		roots_pending = expected_roots.size();
	end
endmodule

@@ tb/quadratic_root_solver_tb.sv @@
// top of the quadratic root solver bench: clock, reset, coefficient stimulus
// and verdict; depends on qrs_pkg, the solver rtl and quadratic_root_solver_chk
module quadratic_root_solver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY   = 17;
	localparam int WDOG_MAX  = 2000;
	localparam int N_RANDOM  = 430;

	logic clk, arst_n, start, busy, done, zero_leading;
	logic signed [qrs_pkg::COEF_W-1:0] coef_a, coef_b, coef_c;
	logic signed [qrs_pkg::ROOT_W-1:0] root1_re, root1_im, root2_re, root2_im;
	logic [1:0] complex_count;
	int fail_count, roots_pending, idle_cycles;
	bit timed_out;

	// 4 ns period
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	quadratic_root_solver u_dut (.*);

	quadratic_root_solver_chk u_chk (.*);

	// watchdog: cycles with no item accepted and no result seen
	always @(posedge clk) begin
		if (start && !busy || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX && !timed_out) begin
			timed_out <= 1'b1;
			$display("end of test: mismatches");
			$finish;
		end
	end

	// hold one item on the ports until it is accepted; gap drives start low ahead of the item
	task automatic send_item(logic [15:0] a, logic [15:0] b, logic [15:0] c, bit gap);
		if (gap) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start  <= 1'b1;
		coef_a <= a;
		coef_b <= b;
		coef_c <= c;
		do @(posedge clk); while (busy);
	endtask

	// pick extreme or random coefficient
	function automatic logic [15:0] pick_coef();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'(signed'($urandom_range(512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] a, b, c;
		bit quiet;
		idle_cycles = 0;
		timed_out   = 1'b0;
		start  = 1'b0;
		coef_a = '0;
		coef_b = '0;
		coef_c = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: leading zero, extremes, real and complex roots, tiny imaginary
		send_item(16'h0000, 16'h1234, 16'h5678, 0);
		send_item(16'h0000, 16'h8000, 16'h7fff, 0);
		send_item(16'h0100, 16'h0000, 16'hff00, 0);   // x^2 - 1, real
		send_item(16'h0100, 16'h0000, 16'h0100, 0);   // x^2 + 1, complex
		send_item(16'h0100, 16'h0200, 16'h0100, 0);   // double root
		send_item(16'h8000, 16'h8000, 16'h8000, 0);
		send_item(16'h7fff, 16'h7fff, 16'h7fff, 0);
		send_item(16'h8000, 16'h7fff, 16'h7fff, 0);
		send_item(16'h7fff, 16'h8000, 16'h8000, 0);
		send_item(16'h8000, 16'h0000, 16'h7fff, 0);
		send_item(16'h7fff, 16'h0000, 16'h7fff, 0);   // large a, complex
		send_item(16'h7fff, 16'h0000, 16'h0001, 0);   // tiny imaginary part
		send_item(16'h8000, 16'h0001, 16'h8000, 0);
		send_item(16'h0001, 16'h7fff, 16'h0001, 0);
		send_item(16'hffff, 16'hffff, 16'hffff, 0);
		send_item(16'h0001, 16'h0000, 16'h0001, 0);
		send_item(16'hffff, 16'h8000, 16'h0000, 0);
		send_item(16'h5555, 16'haaaa, 16'h5555, 0);
		send_item(16'haaaa, 16'h5555, 16'haaaa, 0);

		// hold off until the pipe drains once
		start <= 1'b0;
		@(posedge clk);
		while (roots_pending != 0) @(posedge clk);

		for (int i = 0; i < N_RANDOM; i++) begin
			quiet = (i >= 150 && i < 250);
			a = pick_coef();
			b = pick_coef();
			c = pick_coef();
			send_item(a, b, c, !quiet && $urandom_range(99) < 7);
		end
		start <= 1'b0;

		while (roots_pending != 0) @(posedge clk);
		repeat (LATENCY + 3) @(posedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
